[hw/rtl/ppcr_pkg.sv]
// shared types and constants for the particle pair contact resolver
// payload structs, pipeline context, register codes; no dependencies
package ppcr_pkg;

	localparam int FRAC_BITS = 16;
	localparam int WORD_W = 32;
	localparam int MAG_W = 31;
	localparam int WSUM_W = WORD_W + 1;
	localparam int SQ_W = 2 * MAG_W;
	localparam int SUM_W = SQ_W + 2;
	localparam int WPROD_W = MAG_W + WORD_W;
	localparam int VNUM_W = MAG_W + FRAC_BITS;
	localparam int SQRT_REM_W = MAG_W + 2;
	localparam int SQRT_SH_W = MAG_W + 4;
	localparam int SQRT_STEPS = MAG_W;
	localparam int CDIV_STEPS = MAG_W;
	localparam int WDIV_STEPS = MAG_W;
	localparam int VDIV_STEPS = VNUM_W;
	localparam int AXES = 3;
	localparam int LANES = 2 * AXES;
	localparam int CFG_IDX_W = 2;

	localparam logic [MAG_W-1:0] THICKNESS_RESET = MAG_W'(6554);
	localparam logic [MAG_W-1:0] TIME_STEP_RESET = MAG_W'(1092);
	localparam logic [VNUM_W-1:0] VEL_POS_LIMIT = VNUM_W'(33'h07fffffff);
	localparam logic [VNUM_W-1:0] VEL_NEG_LIMIT = VNUM_W'(33'h080000000);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_THICKNESS = 2'd0,
		CFG_TIME_STEP = 2'd1
	} cfg_reg_t;

	typedef struct packed {
		logic signed [WORD_W-1:0] first_x;
		logic signed [WORD_W-1:0] first_y;
		logic signed [WORD_W-1:0] first_z;
		logic signed [WORD_W-1:0] second_x;
		logic signed [WORD_W-1:0] second_y;
		logic signed [WORD_W-1:0] second_z;
		logic [WORD_W-1:0] first_inv_mass;
		logic [WORD_W-1:0] second_inv_mass;
	} pair_t;

	typedef struct packed {
		logic signed [WORD_W-1:0] first_dx;
		logic signed [WORD_W-1:0] first_dy;
		logic signed [WORD_W-1:0] first_dz;
		logic signed [WORD_W-1:0] second_dx;
		logic signed [WORD_W-1:0] second_dy;
		logic signed [WORD_W-1:0] second_dz;
		logic signed [WORD_W-1:0] first_vel_dx;
		logic signed [WORD_W-1:0] first_vel_dy;
		logic signed [WORD_W-1:0] first_vel_dz;
		logic signed [WORD_W-1:0] second_vel_dx;
		logic signed [WORD_W-1:0] second_vel_dy;
		logic signed [WORD_W-1:0] second_vel_dz;
	} result_t;

	// per item context that rides along the pipe
	typedef struct packed {
		logic kill;
		logic [AXES-1:0] neg;
		logic [WORD_W-1:0] w1;
		logic [WORD_W-1:0] w2;
		logic [WSUM_W-1:0] wsum;
		logic [AXES-1:0][MAG_W-1:0] mag;
		logic [MAG_W-1:0] span;
		logic [MAG_W-1:0] pen;
	} ctx_t;

endpackage

[hw/rtl/particle_pair_contact_resolve.sv]
// particle pair contact resolver, top level
// depends on ppcr_pkg
//
// usage:
// - pair channel (pair_valid, pair_stall, pair): one candidate pair per item,
//   two Q16.16 positions and two inverse masses
// - result channel (result_valid, result_stall, result): one item per pair,
//   position corrections and saturated velocity deltas for both particles
// - cfg channel (cfg_valid, cfg_ready, cfg_index, cfg_data): contact
//   thickness at index 0, time step at index 1, low 31 bits used;
//   cfg_ready is always high, write only while no item is in flight
// - throughput: one item per cycle while the output register is not held,
//   set by the fully pipelined datapath
// - pipeline: 3 front stages, 31 square root steps, 2 stages, 31 steps
//   of the normal divide, 1 stage, 31 steps of the mass share divide,
//   47 steps of the time step divide, output register
// - every stage advances together; while result_valid and result_stall
//   are both high the whole pipe holds and pair_stall is high
// - reset empties the pipe and loads thickness 6554 and time step 1092
module particle_pair_contact_resolve (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                pair_valid,
	output logic                                pair_stall,
	input  ppcr_pkg::pair_t                     pair,
	output logic                                result_valid,
	input  logic                                result_stall,
	output ppcr_pkg::result_t                   result,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [ppcr_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [ppcr_pkg::WORD_W-1:0]         cfg_data
);
	import ppcr_pkg::*;

	logic adv;
	logic [MAG_W-1:0] thick_q;
	logic [MAG_W-1:0] step_q;
	logic [SQ_W-1:0] thick_sq_q;

	// whole pipe moves unless the output register is full and held
	assign adv = !(result_valid && result_stall);
	assign pair_stall = !adv;
	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thick_q <= THICKNESS_RESET;
			step_q <= TIME_STEP_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_reg_t'(cfg_index))
				CFG_THICKNESS: thick_q <= cfg_data[MAG_W-1:0];
				CFG_TIME_STEP: step_q <= cfg_data[MAG_W-1:0];
				default: ;
			endcase
		end
	end

	// squared thickness for the exact contact test, follows the register
	always_ff @(posedge clk) begin
		thick_sq_q <= SQ_W'(thick_q) * SQ_W'(thick_q);
	end

	// ---------------- stage 1: deltas, magnitudes, early rejects
	logic [WORD_W-1:0] first_pos [AXES];
	logic [WORD_W-1:0] second_pos [AXES];
	logic [WORD_W:0] diff [AXES];
	logic [WORD_W:0] mag_full [AXES];
	logic [AXES-1:0] far;
	ctx_t ctx_in;
	ctx_t ctx_s1;
	logic valid_s1;

	assign first_pos[0] = pair.first_x;
	assign first_pos[1] = pair.first_y;
	assign first_pos[2] = pair.first_z;
	assign second_pos[0] = pair.second_x;
	assign second_pos[1] = pair.second_y;
	assign second_pos[2] = pair.second_z;

	always_comb begin
		ctx_in = '0;
		for (int a = 0; a < AXES; a++) begin
			diff[a] = {second_pos[a][WORD_W-1], second_pos[a]}
				- {first_pos[a][WORD_W-1], first_pos[a]};
			mag_full[a] = diff[a][WORD_W] ? (~diff[a] + 1'b1) : diff[a];
			far[a] = mag_full[a] >= {2'b00, thick_q};
			ctx_in.neg[a] = diff[a][WORD_W];
			ctx_in.mag[a] = mag_full[a][MAG_W-1:0];
		end
		ctx_in.w1 = pair.first_inv_mass;
		ctx_in.w2 = pair.second_inv_mass;
		ctx_in.wsum = {1'b0, pair.first_inv_mass} + {1'b0, pair.second_inv_mass};
		ctx_in.kill = (|far) || (ctx_in.wsum == '0) || (step_q == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= pair_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ctx_s1 <= ctx_in;
		end
	end

	// ---------------- stage 2: squares
	logic [SQ_W-1:0] sq_s2 [AXES];
	ctx_t ctx_s2;
	logic valid_s2;

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int a = 0; a < AXES; a++) begin
				sq_s2[a] <= SQ_W'(ctx_s1.mag[a]) * SQ_W'(ctx_s1.mag[a]);
			end
			ctx_s2 <= ctx_s1;
		end
	end

	// ---------------- stage 3: squared distance and contact test
	logic [SUM_W-1:0] d2_sum;
	logic kill3;
	ctx_t ctx3_in;
	logic [SQ_W-1:0] d2_s3;
	ctx_t ctx_s3;
	logic valid_s3;

	always_comb begin
		d2_sum = SUM_W'(sq_s2[0]) + SUM_W'(sq_s2[1]) + SUM_W'(sq_s2[2]);
		kill3 = ctx_s2.kill || (d2_sum == '0) || (d2_sum >= SUM_W'(thick_sq_q));
		ctx3_in = ctx_s2;
		ctx3_in.kill = kill3;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			d2_s3 <= kill3 ? '0 : d2_sum[SQ_W-1:0];
			ctx_s3 <= ctx3_in;
		end
	end

	// ---------------- square root, one result bit per stage
	logic [SQ_W-1:0] sqrt_rad_s [SQRT_STEPS];
	logic [SQRT_REM_W-1:0] sqrt_rem_s [SQRT_STEPS];
	logic [MAG_W-1:0] sqrt_root_s [SQRT_STEPS];
	ctx_t sqrt_ctx_s [SQRT_STEPS];
	logic sqrt_vld_s [SQRT_STEPS];
	logic [SQ_W-1:0] sqrt_rad_in [SQRT_STEPS];
	logic [SQRT_REM_W-1:0] sqrt_rem_in [SQRT_STEPS];
	logic [MAG_W-1:0] sqrt_root_in [SQRT_STEPS];
	ctx_t sqrt_ctx_in [SQRT_STEPS];
	logic sqrt_vld_in [SQRT_STEPS];
	logic [SQRT_SH_W-1:0] sqrt_sh [SQRT_STEPS];
	logic [SQRT_SH_W-1:0] sqrt_trial [SQRT_STEPS];
	logic sqrt_ge [SQRT_STEPS];

	always_comb begin
		sqrt_rad_in[0] = d2_s3;
		sqrt_rem_in[0] = '0;
		sqrt_root_in[0] = '0;
		sqrt_ctx_in[0] = ctx_s3;
		sqrt_vld_in[0] = valid_s3;
		for (int k = 1; k < SQRT_STEPS; k++) begin
			sqrt_rad_in[k] = sqrt_rad_s[k-1];
			sqrt_rem_in[k] = sqrt_rem_s[k-1];
			sqrt_root_in[k] = sqrt_root_s[k-1];
			sqrt_ctx_in[k] = sqrt_ctx_s[k-1];
			sqrt_vld_in[k] = sqrt_vld_s[k-1];
		end
		for (int k = 0; k < SQRT_STEPS; k++) begin
			sqrt_sh[k] = {sqrt_rem_in[k], sqrt_rad_in[k][SQ_W-1 -: 2]};
			sqrt_trial[k] = {2'b00, sqrt_root_in[k], 2'b01};
			sqrt_ge[k] = sqrt_sh[k] >= sqrt_trial[k];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < SQRT_STEPS; k++) begin
				sqrt_rad_s[k] <= sqrt_rad_in[k] << 2;
				sqrt_rem_s[k] <= sqrt_ge[k] ? SQRT_REM_W'(sqrt_sh[k] - sqrt_trial[k])
					: sqrt_sh[k][SQRT_REM_W-1:0];
				sqrt_root_s[k] <= {sqrt_root_in[k][MAG_W-2:0], sqrt_ge[k]};
				sqrt_ctx_s[k] <= sqrt_ctx_in[k];
			end
		end
	end

	// ---------------- stage 4: penetration depth
	ctx_t ctx4_in;
	ctx_t ctx_s4;
	logic valid_s4;

	always_comb begin
		ctx4_in = sqrt_ctx_s[SQRT_STEPS-1];
		ctx4_in.span = sqrt_root_s[SQRT_STEPS-1];
		ctx4_in.pen = thick_q - sqrt_root_s[SQRT_STEPS-1];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ctx_s4 <= ctx4_in;
		end
	end

	// ---------------- stage 5: |d| * pen per axis
	logic [SQ_W-1:0] prod_s5 [AXES];
	ctx_t ctx_s5;
	logic valid_s5;

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int a = 0; a < AXES; a++) begin
				prod_s5[a] <= SQ_W'(ctx_s4.mag[a]) * SQ_W'(ctx_s4.pen);
			end
			ctx_s5 <= ctx_s4;
		end
	end

	// ---------------- correction magnitude: product / distance
	// quotient stays below 2^31, so the upper half starts as the remainder
	logic [MAG_W-1:0] cdiv_rem_s [CDIV_STEPS][AXES];
	logic [MAG_W-1:0] cdiv_num_s [CDIV_STEPS][AXES];
	logic [MAG_W-1:0] cdiv_q_s [CDIV_STEPS][AXES];
	ctx_t cdiv_ctx_s [CDIV_STEPS];
	logic cdiv_vld_s [CDIV_STEPS];
	logic [MAG_W-1:0] cdiv_rem_in [CDIV_STEPS][AXES];
	logic [MAG_W-1:0] cdiv_num_in [CDIV_STEPS][AXES];
	logic [MAG_W-1:0] cdiv_q_in [CDIV_STEPS][AXES];
	ctx_t cdiv_ctx_in [CDIV_STEPS];
	logic cdiv_vld_in [CDIV_STEPS];
	logic [MAG_W:0] cdiv_sh [CDIV_STEPS][AXES];
	logic cdiv_ge [CDIV_STEPS][AXES];

	always_comb begin
		for (int a = 0; a < AXES; a++) begin
			cdiv_rem_in[0][a] = prod_s5[a][SQ_W-1:MAG_W];
			cdiv_num_in[0][a] = prod_s5[a][MAG_W-1:0];
			cdiv_q_in[0][a] = '0;
		end
		cdiv_ctx_in[0] = ctx_s5;
		cdiv_vld_in[0] = valid_s5;
		for (int k = 1; k < CDIV_STEPS; k++) begin
			for (int a = 0; a < AXES; a++) begin
				cdiv_rem_in[k][a] = cdiv_rem_s[k-1][a];
				cdiv_num_in[k][a] = cdiv_num_s[k-1][a];
				cdiv_q_in[k][a] = cdiv_q_s[k-1][a];
			end
			cdiv_ctx_in[k] = cdiv_ctx_s[k-1];
			cdiv_vld_in[k] = cdiv_vld_s[k-1];
		end
		for (int k = 0; k < CDIV_STEPS; k++) begin
			for (int a = 0; a < AXES; a++) begin
				cdiv_sh[k][a] = {cdiv_rem_in[k][a], cdiv_num_in[k][a][MAG_W-1]};
				cdiv_ge[k][a] = cdiv_sh[k][a] >= {1'b0, cdiv_ctx_in[k].span};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < CDIV_STEPS; k++) begin
				for (int a = 0; a < AXES; a++) begin
					cdiv_rem_s[k][a] <= cdiv_ge[k][a]
						? MAG_W'(cdiv_sh[k][a] - {1'b0, cdiv_ctx_in[k].span})
						: cdiv_sh[k][a][MAG_W-1:0];
					cdiv_num_s[k][a] <= cdiv_num_in[k][a] << 1;
					cdiv_q_s[k][a] <= {cdiv_q_in[k][a][MAG_W-2:0], cdiv_ge[k][a]};
				end
				cdiv_ctx_s[k] <= cdiv_ctx_in[k];
			end
		end
	end

	// ---------------- stage 6: correction times each inverse mass
	// lanes 0..2 are the first particle, 3..5 the second
	logic [WPROD_W-1:0] wp_s6 [LANES];
	ctx_t ctx_s6;
	logic valid_s6;

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int a = 0; a < AXES; a++) begin
				wp_s6[a] <= WPROD_W'(cdiv_q_s[CDIV_STEPS-1][a])
					* WPROD_W'(cdiv_ctx_s[CDIV_STEPS-1].w1);
				wp_s6[a+AXES] <= WPROD_W'(cdiv_q_s[CDIV_STEPS-1][a])
					* WPROD_W'(cdiv_ctx_s[CDIV_STEPS-1].w2);
			end
			ctx_s6 <= cdiv_ctx_s[CDIV_STEPS-1];
		end
	end

	// ---------------- mass share: product / (w1 + w2)
	logic [WSUM_W-1:0] wdiv_rem_s [WDIV_STEPS][LANES];
	logic [MAG_W-1:0] wdiv_num_s [WDIV_STEPS][LANES];
	logic [MAG_W-1:0] wdiv_q_s [WDIV_STEPS][LANES];
	ctx_t wdiv_ctx_s [WDIV_STEPS];
	logic wdiv_vld_s [WDIV_STEPS];
	logic [WSUM_W-1:0] wdiv_rem_in [WDIV_STEPS][LANES];
	logic [MAG_W-1:0] wdiv_num_in [WDIV_STEPS][LANES];
	logic [MAG_W-1:0] wdiv_q_in [WDIV_STEPS][LANES];
	ctx_t wdiv_ctx_in [WDIV_STEPS];
	logic wdiv_vld_in [WDIV_STEPS];
	logic [WSUM_W:0] wdiv_sh [WDIV_STEPS][LANES];
	logic wdiv_ge [WDIV_STEPS][LANES];

	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			wdiv_rem_in[0][l] = {1'b0, wp_s6[l][WPROD_W-1:MAG_W]};
			wdiv_num_in[0][l] = wp_s6[l][MAG_W-1:0];
			wdiv_q_in[0][l] = '0;
		end
		wdiv_ctx_in[0] = ctx_s6;
		wdiv_vld_in[0] = valid_s6;
		for (int k = 1; k < WDIV_STEPS; k++) begin
			for (int l = 0; l < LANES; l++) begin
				wdiv_rem_in[k][l] = wdiv_rem_s[k-1][l];
				wdiv_num_in[k][l] = wdiv_num_s[k-1][l];
				wdiv_q_in[k][l] = wdiv_q_s[k-1][l];
			end
			wdiv_ctx_in[k] = wdiv_ctx_s[k-1];
			wdiv_vld_in[k] = wdiv_vld_s[k-1];
		end
		for (int k = 0; k < WDIV_STEPS; k++) begin
			for (int l = 0; l < LANES; l++) begin
				wdiv_sh[k][l] = {wdiv_rem_in[k][l], wdiv_num_in[k][l][MAG_W-1]};
				wdiv_ge[k][l] = wdiv_sh[k][l] >= {1'b0, wdiv_ctx_in[k].wsum};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < WDIV_STEPS; k++) begin
				for (int l = 0; l < LANES; l++) begin
					wdiv_rem_s[k][l] <= wdiv_ge[k][l]
						? WSUM_W'(wdiv_sh[k][l] - {1'b0, wdiv_ctx_in[k].wsum})
						: wdiv_sh[k][l][WSUM_W-1:0];
					wdiv_num_s[k][l] <= wdiv_num_in[k][l] << 1;
					wdiv_q_s[k][l] <= {wdiv_q_in[k][l][MAG_W-2:0], wdiv_ge[k][l]};
				end
				wdiv_ctx_s[k] <= wdiv_ctx_in[k];
			end
		end
	end

	// ---------------- velocity: (share << FRAC_BITS) / time step
	logic [MAG_W-1:0] vdiv_rem_s [VDIV_STEPS][LANES];
	logic [VNUM_W-1:0] vdiv_num_s [VDIV_STEPS][LANES];
	logic [VNUM_W-1:0] vdiv_q_s [VDIV_STEPS][LANES];
	logic [MAG_W-1:0] vdiv_mag_s [VDIV_STEPS][LANES];
	ctx_t vdiv_ctx_s [VDIV_STEPS];
	logic vdiv_vld_s [VDIV_STEPS];
	logic [MAG_W-1:0] vdiv_rem_in [VDIV_STEPS][LANES];
	logic [VNUM_W-1:0] vdiv_num_in [VDIV_STEPS][LANES];
	logic [VNUM_W-1:0] vdiv_q_in [VDIV_STEPS][LANES];
	logic [MAG_W-1:0] vdiv_mag_in [VDIV_STEPS][LANES];
	ctx_t vdiv_ctx_in [VDIV_STEPS];
	logic vdiv_vld_in [VDIV_STEPS];
	logic [MAG_W:0] vdiv_sh [VDIV_STEPS][LANES];
	logic vdiv_ge [VDIV_STEPS][LANES];

	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			vdiv_rem_in[0][l] = '0;
			vdiv_num_in[0][l] = {wdiv_q_s[WDIV_STEPS-1][l], FRAC_BITS'(0)};
			vdiv_q_in[0][l] = '0;
			vdiv_mag_in[0][l] = wdiv_q_s[WDIV_STEPS-1][l];
		end
		vdiv_ctx_in[0] = wdiv_ctx_s[WDIV_STEPS-1];
		vdiv_vld_in[0] = wdiv_vld_s[WDIV_STEPS-1];
		for (int k = 1; k < VDIV_STEPS; k++) begin
			for (int l = 0; l < LANES; l++) begin
				vdiv_rem_in[k][l] = vdiv_rem_s[k-1][l];
				vdiv_num_in[k][l] = vdiv_num_s[k-1][l];
				vdiv_q_in[k][l] = vdiv_q_s[k-1][l];
				vdiv_mag_in[k][l] = vdiv_mag_s[k-1][l];
			end
			vdiv_ctx_in[k] = vdiv_ctx_s[k-1];
			vdiv_vld_in[k] = vdiv_vld_s[k-1];
		end
		for (int k = 0; k < VDIV_STEPS; k++) begin
			for (int l = 0; l < LANES; l++) begin
				vdiv_sh[k][l] = {vdiv_rem_in[k][l], vdiv_num_in[k][l][VNUM_W-1]};
				vdiv_ge[k][l] = vdiv_sh[k][l] >= {1'b0, step_q};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < VDIV_STEPS; k++) begin
				for (int l = 0; l < LANES; l++) begin
					vdiv_rem_s[k][l] <= vdiv_ge[k][l]
						? MAG_W'(vdiv_sh[k][l] - {1'b0, step_q})
						: vdiv_sh[k][l][MAG_W-1:0];
					vdiv_num_s[k][l] <= vdiv_num_in[k][l] << 1;
					vdiv_q_s[k][l] <= {vdiv_q_in[k][l][VNUM_W-2:0], vdiv_ge[k][l]};
					vdiv_mag_s[k][l] <= vdiv_mag_in[k][l];
				end
				vdiv_ctx_s[k] <= vdiv_ctx_in[k];
			end
		end
	end

	// ---------------- signs, saturation, rejects; output register
	ctx_t fin_ctx;
	logic fin_neg [LANES];
	logic [VNUM_W-1:0] fin_lim [LANES];
	logic [WORD_W-1:0] fin_vmag [LANES];
	logic [WORD_W-1:0] fin_pos [LANES];
	logic [WORD_W-1:0] fin_vel [LANES];
	result_t result_c;

	always_comb begin
		fin_ctx = vdiv_ctx_s[VDIV_STEPS-1];
		for (int a = 0; a < AXES; a++) begin
			// first particle moves against the delta, second along it
			fin_neg[a] = !fin_ctx.neg[a];
			fin_neg[a+AXES] = fin_ctx.neg[a];
		end
		for (int l = 0; l < LANES; l++) begin
			fin_lim[l] = fin_neg[l] ? VEL_NEG_LIMIT : VEL_POS_LIMIT;
			fin_vmag[l] = (vdiv_q_s[VDIV_STEPS-1][l] > fin_lim[l])
				? fin_lim[l][WORD_W-1:0] : vdiv_q_s[VDIV_STEPS-1][l][WORD_W-1:0];
			fin_pos[l] = fin_neg[l] ? (~{1'b0, vdiv_mag_s[VDIV_STEPS-1][l]} + 1'b1)
				: {1'b0, vdiv_mag_s[VDIV_STEPS-1][l]};
			fin_vel[l] = fin_neg[l] ? (~fin_vmag[l] + 1'b1) : fin_vmag[l];
			if (fin_ctx.kill) begin
				fin_pos[l] = '0;
				fin_vel[l] = '0;
			end
		end
		result_c.first_dx = fin_pos[0];
		result_c.first_dy = fin_pos[1];
		result_c.first_dz = fin_pos[2];
		result_c.second_dx = fin_pos[3];
		result_c.second_dy = fin_pos[4];
		result_c.second_dz = fin_pos[5];
		result_c.first_vel_dx = fin_vel[0];
		result_c.first_vel_dy = fin_vel[1];
		result_c.first_vel_dz = fin_vel[2];
		result_c.second_vel_dx = fin_vel[3];
		result_c.second_vel_dy = fin_vel[4];
		result_c.second_vel_dz = fin_vel[5];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			result <= result_c;
		end
	end

	// valid bits of every stage after the first
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
			result_valid <= 1'b0;
			for (int k = 0; k < SQRT_STEPS; k++) begin
				sqrt_vld_s[k] <= 1'b0;
			end
			for (int k = 0; k < CDIV_STEPS; k++) begin
				cdiv_vld_s[k] <= 1'b0;
			end
			for (int k = 0; k < WDIV_STEPS; k++) begin
				wdiv_vld_s[k] <= 1'b0;
			end
			for (int k = 0; k < VDIV_STEPS; k++) begin
				vdiv_vld_s[k] <= 1'b0;
			end
		end else if (adv) begin
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= sqrt_vld_s[SQRT_STEPS-1];
			valid_s5 <= valid_s4;
			valid_s6 <= cdiv_vld_s[CDIV_STEPS-1];
			result_valid <= vdiv_vld_s[VDIV_STEPS-1];
			for (int k = 0; k < SQRT_STEPS; k++) begin
				sqrt_vld_s[k] <= sqrt_vld_in[k];
			end
			for (int k = 0; k < CDIV_STEPS; k++) begin
				cdiv_vld_s[k] <= cdiv_vld_in[k];
			end
			for (int k = 0; k < WDIV_STEPS; k++) begin
				wdiv_vld_s[k] <= wdiv_vld_in[k];
			end
			for (int k = 0; k < VDIV_STEPS; k++) begin
				vdiv_vld_s[k] <= vdiv_vld_in[k];
			end
		end
	end

	// a pair in contact has a distance below the thickness
	a_dist_below_thickness: assert property (@(posedge clk) disable iff (!arst_n)
		sqrt_vld_s[SQRT_STEPS-1] && !sqrt_ctx_s[SQRT_STEPS-1].kill
		|-> sqrt_root_s[SQRT_STEPS-1] < thick_q)
		else $error("square root reached the contact thickness");

	// |d| <= distance, so the correction never exceeds the penetration
	a_corr_within_pen: assert property (@(posedge clk) disable iff (!arst_n)
		cdiv_vld_s[CDIV_STEPS-1] && !cdiv_ctx_s[CDIV_STEPS-1].kill
		|-> cdiv_q_s[CDIV_STEPS-1][0] <= cdiv_ctx_s[CDIV_STEPS-1].pen
			&& cdiv_q_s[CDIV_STEPS-1][1] <= cdiv_ctx_s[CDIV_STEPS-1].pen
			&& cdiv_q_s[CDIV_STEPS-1][2] <= cdiv_ctx_s[CDIV_STEPS-1].pen)
		else $error("correction larger than penetration");

	// normal divide remainders end below the divisor
	a_cdiv_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cdiv_vld_s[CDIV_STEPS-1] && !cdiv_ctx_s[CDIV_STEPS-1].kill
		|-> cdiv_rem_s[CDIV_STEPS-1][0] < cdiv_ctx_s[CDIV_STEPS-1].span
			&& cdiv_rem_s[CDIV_STEPS-1][1] < cdiv_ctx_s[CDIV_STEPS-1].span
			&& cdiv_rem_s[CDIV_STEPS-1][2] < cdiv_ctx_s[CDIV_STEPS-1].span)
		else $error("normal divide remainder out of range");

	// an item leaving the last divide step lands in the output register
	a_last_to_output: assert property (@(posedge clk) disable iff (!arst_n)
		adv && vdiv_vld_s[VDIV_STEPS-1] |=> result_valid)
		else $error("item lost before the output register");

endmodule

[dv/particle_pair_contact_resolve_test.sv]
// testbench for the particle pair contact resolver: directed and random pairs
// under several thickness / time step settings, checked against a scoreboard
// depends on ppcr_pkg and particle_pair_contact_resolve
module particle_pair_contact_resolve_test;
	import ppcr_pkg::*;

	// holds the expected corrections and the register copy used to predict them
	class contact_scoreboard;
		result_t expected_q[$];
		longint unsigned thickness = THICKNESS_RESET;
		longint unsigned step = TIME_STEP_RESET;
		int errors = 0;
		int checked = 0;
		int contacts = 0;

		function void set_reg(cfg_reg_t idx, logic [WORD_W-1:0] data);
			if (idx == CFG_THICKNESS) thickness = data[MAG_W-1:0];
			else if (idx == CFG_TIME_STEP) step = data[MAG_W-1:0];
		endfunction

		function longint unsigned int_sqrt(longint unsigned v);
			longint unsigned r;
			longint unsigned b;
			r = 0;
			b = 64'd1 << 62;
			while (b > v) b = b >> 2;
			while (b != 0) begin
				if (v >= r + b) begin
					v = v - (r + b);
					r = (r >> 1) + b;
				end else begin
					r = r >> 1;
				end
				b = b >> 2;
			end
			return r;
		endfunction

		function logic [WORD_W-1:0] apply_sign(longint unsigned m, bit neg);
			longint unsigned v;
			v = neg ? (64'd0 - m) : m;
			return v[WORD_W-1:0];
		endfunction

		function logic [WORD_W-1:0] vel_delta(longint unsigned m, bit neg);
			longint unsigned v;
			v = (m << FRAC_BITS) / step;
			if (neg && v > 64'h80000000) v = 64'h80000000;
			if (!neg && v > 64'h7fffffff) v = 64'h7fffffff;
			return apply_sign(v, neg);
		endfunction

		function result_t resolve_pair(pair_t p);
			logic signed [WORD_W-1:0] fp[3];
			logic signed [WORD_W-1:0] sp[3];
			logic [WORD_W-1:0] o[12];
			longint unsigned mag[3];
			bit neg[3];
			longint unsigned w1, w2, wsum, d2, span, pen, c, m1, m2;
			longint dd;
			bit touch;
			fp = '{p.first_x, p.first_y, p.first_z};
			sp = '{p.second_x, p.second_y, p.second_z};
			w1 = p.first_inv_mass;
			w2 = p.second_inv_mass;
			wsum = w1 + w2;
			touch = 1;
			d2 = 0;
			foreach (o[i]) o[i] = '0;
			for (int a = 0; a < 3; a++) begin
				dd = longint'(sp[a]) - longint'(fp[a]);
				neg[a] = dd < 0;
				mag[a] = neg[a] ? longint'(-dd) : dd;
				if (mag[a] >= thickness) touch = 0;
			end
			if (touch && wsum != 0 && step != 0) begin
				for (int a = 0; a < 3; a++) d2 += mag[a] * mag[a];
				if (d2 != 0 && d2 < thickness * thickness) begin
					contacts++;
					span = int_sqrt(d2);
					pen = thickness - span;
					for (int a = 0; a < 3; a++) begin
						c = mag[a] * pen / span;
						m1 = c * w1 / wsum;
						m2 = c * w2 / wsum;
						o[a] = apply_sign(m1, !neg[a]);
						o[3+a] = apply_sign(m2, neg[a]);
						o[6+a] = vel_delta(m1, !neg[a]);
						o[9+a] = vel_delta(m2, neg[a]);
					end
				end
			end
			return {o[0], o[1], o[2], o[3], o[4], o[5],
				o[6], o[7], o[8], o[9], o[10], o[11]};
		endfunction

		function void note_pair(pair_t p);
			expected_q = {expected_q, resolve_pair(p)};
		endfunction

		function void check_result(result_t r);
			result_t e;
			string names[12] = '{"first_dx", "first_dy", "first_dz",
				"second_dx", "second_dy", "second_dz",
				"first_vel_dx", "first_vel_dy", "first_vel_dz",
				"second_vel_dx", "second_vel_dy", "second_vel_dz"};
			if (expected_q.size() == 0) begin
				$error("result with nothing expected: %h", r);
				errors++;
				return;
			end
			e = expected_q.pop_front();
			checked++;
			for (int i = 0; i < 12; i++) begin
				if (r[383-32*i -: 32] !== e[383-32*i -: 32]) begin
					$error("%s expected %h got %h", names[i],
						e[383-32*i -: 32], r[383-32*i -: 32]);
					errors++;
				end
			end
		endfunction
	endclass

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int HOLD_CYCLES = 400;

	logic clk = 0;
	logic arst_n = 0;
	logic pair_valid = 0;
	logic pair_stall;
	pair_t pair = '0;
	logic result_valid;
	logic result_stall = 0;
	result_t result;
	logic cfg_valid = 0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [WORD_W-1:0] cfg_data = '0;

	contact_scoreboard sb = new();
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	bit hold_pending = 0;
	int pairs_sent = 0;
	int idle_cycles = 0;

	particle_pair_contact_resolve dut (.*);

	always begin
		#4 clk = 1;
		#4 clk = 0;
	end

	// result side: random stalls, or one long hold when asked for
	initial begin
		forever begin
			@(negedge clk);
			if (hold_pending) begin
				hold_pending = 0;
				repeat (HOLD_CYCLES) begin
					result_stall <= 1;
					@(negedge clk);
				end
			end
			result_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	// score every accepted result
	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) sb.check_result(result);
	end

	// watchdog: cycles without any handshake
	always @(posedge clk) begin
		if ((pair_valid && !pair_stall) || (result_valid && !result_stall) ||
				(cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog expired with %0d items outstanding", sb.expected_q.size());
			$display("particle_pair_contact_resolve_test: errors");
			$finish;
		end
	end

	// offer one pair, holding it until it is taken; called at a falling edge
	task automatic send_pair(pair_t p);
		while ($urandom_range(99) < send_idle_pct) begin
			pair_valid <= 0;
			@(negedge clk);
		end
		pair_valid <= 1;
		pair <= p;
		@(posedge clk);
		while (pair_stall) @(posedge clk);
		sb.note_pair(p);
		pairs_sent++;
		@(negedge clk);
	endtask

	task automatic drain();
		pair_valid <= 0;
		while (sb.expected_q.size() != 0) @(negedge clk);
	endtask

	// one register write, with cfg_valid dropped again before anything else is driven
	task automatic write_reg(cfg_reg_t idx, logic [WORD_W-1:0] data);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		sb.set_reg(idx, data);
		@(negedge clk);
		cfg_valid <= 0;
		@(negedge clk);
	endtask

	function automatic logic [WORD_W-1:0] pick_mass();
		case ($urandom_range(5))
			0: return '0;
			1: return $urandom_range(65536);
			2: return '1;
			default: return $urandom;
		endcase
	endfunction

	// mostly pairs inside the contact sphere, some arbitrary noise
	function automatic pair_t make_pair();
		pair_t p;
		longint unsigned t;
		logic [WORD_W-1:0] off[3];
		t = sb.thickness;
		p = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
			pick_mass(), pick_mass()};
		if (t > 2 && $urandom_range(9) < 8) begin
			for (int a = 0; a < 3; a++) begin
				off[a] = $urandom_range(32'(t / 2));
				if ($urandom_range(1)) off[a] = -off[a];
			end
			p.second_x = p.first_x + off[0];
			p.second_y = p.first_y + off[1];
			p.second_z = p.first_z + off[2];
		end
		if ($urandom_range(29) == 0) p.second_inv_mass = '0;
		return p;
	endfunction

	task automatic run_random(int count);
		repeat (count) send_pair(make_pair());
	endtask

	task automatic set_idling(int send_pct, int recv_pct);
		send_idle_pct = send_pct;
		recv_stall_pct = recv_pct;
	endtask

	initial begin
		pair_t p;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// directed pairs at the reset settings
		p = '{first_x: 100, first_y: 200, first_z: -50, second_x: 1100,
			second_y: 700, second_z: -1050, first_inv_mass: 0,
			second_inv_mass: 0, default: '0};
		send_pair(p); // both masses fixed
		p.first_inv_mass = 32'h10000;
		p.second_inv_mass = 32'h10000;
		send_pair(p); // equal masses, contact
		p.second_inv_mass = 0;
		send_pair(p); // only the first one moves
		p.first_inv_mass = 0;
		p.second_inv_mass = '1;
		send_pair(p); // only the second one moves, largest inverse mass
		p.first_inv_mass = '1;
		send_pair(p); // both inverse masses at maximum
		p.second_x = p.first_x;
		p.second_y = p.first_y;
		p.second_z = p.first_z;
		send_pair(p); // coincident particles
		p.second_x = p.first_x + 6554;
		send_pair(p); // one axis exactly at thickness
		p.second_x = p.first_x - 6553;
		send_pair(p); // just inside on one axis
		p.second_x = p.first_x + 4000;
		p.second_y = p.first_y - 4000;
		p.second_z = p.first_z + 4000;
		send_pair(p); // every axis inside, distance outside
		p.second_x = p.first_x - 3000;
		p.second_y = p.first_y + 3000;
		p.second_z = p.first_z - 3000;
		send_pair(p); // inside, mixed signs
		p = {32'h80000000, 32'h80000000, 32'h80000000,
			32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h1, 32'h1};
		send_pair(p); // widest separation on every axis
		p = {32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
			32'h7ffffff0, 32'h80000000, 32'h7fffffff, 32'hffff, 32'h3};
		send_pair(p); // positions at the top of the range, but second_y at the bottom
		p = {32'h80000000, 32'h80000005, 32'h7fffffff,
			32'h80000001, 32'h80000000, 32'h7ffffff0, 32'h1, 32'hffffffff};
		send_pair(p); // positions at the bottom of the range, but the z axis at the top
		run_random(100);
		drain();

		// largest thickness, upper bit of the data set, smallest time step
		write_reg(CFG_THICKNESS, '1);
		write_reg(CFG_TIME_STEP, 32'h80000001);
		set_idling(85, 0);
		run_random(100);
		drain();

		write_reg(CFG_THICKNESS, 32'h10000);
		write_reg(CFG_TIME_STEP, 32'h7fffffff);
		set_idling(0, 85);
		run_random(100);
		drain();

		// zero thickness: nothing is ever in contact
		write_reg(CFG_THICKNESS, 0);
		write_reg(CFG_TIME_STEP, 1092);
		set_idling(20, 20);
		run_random(50);
		drain();

		// zero time step disables the corrections
		write_reg(CFG_THICKNESS, 300000);
		write_reg(CFG_TIME_STEP, 0);
		run_random(50);
		drain();

		// long receiver hold so the pipe fills and pushes back on the input
		write_reg(CFG_THICKNESS, 6554);
		write_reg(CFG_TIME_STEP, 1092);
		set_idling(0, 0);
		hold_pending = 1;
		run_random(200);
		drain();

		write_reg(CFG_THICKNESS, 32'h100000);
		write_reg(CFG_TIME_STEP, 65536);
		set_idling(20, 20);
		run_random(100);
		drain();

		set_idling(0, 0);
		repeat (200) @(posedge clk);
		$display("sent %0d pairs over seven register settings, %0d in contact",
			pairs_sent, sb.contacts);
		$display("checked %0d results, %0d mismatches", sb.checked, sb.errors);
		if (sb.errors == 0 && sb.expected_q.size() == 0)
			$display("particle_pair_contact_resolve_test: clean");
		else
			$display("particle_pair_contact_resolve_test: errors");
		$finish;
	end

endmodule

[files.f]
hw/rtl/ppcr_pkg.sv
hw/rtl/particle_pair_contact_resolve.sv
dv/particle_pair_contact_resolve_test.sv
